@@ src/ost_pkg.sv @@
package ost_pkg;

  // Fixed field widths of the item and result formats.
  localparam int TimeW   = 32;
  localparam int SlotW   = 11;
  localparam int IdxW    = 10;
  localparam int ValW    = 16;
  localparam int CfgIdxW = 3;
  localparam int InDataW = 48;
  localparam int OutDataW = 240;

  // Register values after reset.
  localparam logic [TimeW-1:0] StartReset  = 32'd0;
  localparam logic [TimeW-1:0] EndReset    = 32'd86400;
  localparam logic [TimeW-1:0] IlenReset   = 32'd3600;
  localparam logic [SlotW-1:0] IcntReset   = 11'd25;
  localparam logic [TimeW-1:0] RecipReset  = 32'd49710;
  localparam logic [TimeW-1:0] FirstReset  = 32'd86400;

  // Request kinds carried on the input tuser.
  typedef enum logic [1:0] {
    ACT_INC   = 2'd0,
    ACT_DEC   = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_READ  = 2'd3
  } action_e;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_START  = 3'd0,
    CFG_END    = 3'd1,
    CFG_ILEN   = 3'd2,
    CFG_ICNT   = 3'd3,
    CFG_RECIP  = 3'd4,
    CFG_FIRST  = 3'd5
  } cfg_idx_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic clear;
    logic close;
    logic update;
    logic mul_first;
    logic mul_second;
    logic accum;
    logic read;
    logic out_load;
  } ost_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic slot_full;
    logic close_step;
    logic before_start;
  } ost_status_t;

  // Result layout, last field in the lowest bits.
  typedef struct packed {
    logic [4:0]       pad;
    logic [SlotW-1:0] intervals_closed;
    logic [ValW-1:0]  interval_value;
    logic [TimeW-1:0] average_count;
    logic [TimeW-1:0] last_exit;
    logic [TimeW-1:0] first_entry;
    logic [TimeW-1:0] max_time;
    logic [ValW-1:0]  max_count;
    logic [TimeW-1:0] min_time;
    logic [ValW-1:0]  min_count;
    logic [ValW-1:0]  current_count;
  } result_t;

endpackage

@@ src/ost_datapath.sv @@
module ost_datapath #(
  parameter int MAX_INTERVALS = 1024,
  parameter int COUNT_BITS    = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ost_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [ost_pkg::TimeW-1:0]     cfg_data_i,
  input  ost_pkg::action_e              in_action_i,
  input  logic [ost_pkg::TimeW-1:0]     in_time_i,
  input  logic [ost_pkg::IdxW-1:0]      in_index_i,
  input  ost_pkg::ost_cmd_t             cmd_i,
  output ost_pkg::ost_status_t          status_o,
  output ost_pkg::result_t              result_o
);
  import ost_pkg::*;

  localparam int AddrW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
  localparam int CntW  = COUNT_BITS;
  localparam logic [SlotW-1:0] LimCap =
    (MAX_INTERVALS > 2047) ? {SlotW{1'b1}} : SlotW'(MAX_INTERVALS);

  // Configuration registers.
  logic [TimeW-1:0] start_q, end_q, ilen_q, recip_q, first_q;
  logic [SlotW-1:0] icnt_q;

  // Statistics state.
  logic [CntW-1:0]  occ_q, least_q, most_q;
  logic [TimeW-1:0] least_t_q, most_t_q, early_q, late_q;
  logic [TimeW-1:0] prior_q, bound_q, wsum_q;
  logic [SlotW-1:0] slot_q;

  // Per-request working registers.
  logic [TimeW-1:0] t_q, d_q;
  logic [IdxW-1:0]  idx_q;
  logic             up_q, big_q, hit_q;
  logic [63:0]      mul_q;
  logic [ValW-1:0]  rd_q;
  result_t          result_q;

  // Interval store, valid below the slot index.
  logic [ValW-1:0]  store_q [MAX_INTERVALS];

  logic [SlotW-1:0]       lim;
  logic [TimeW:0]         next_b;
  logic [CntW-1:0]        occ_n;
  logic [TimeW-1:0]       tc, d;
  logic [TimeW-1:0]       mul_a, mul_b;
  logic [63:0]            prod;
  logic                   term_sat;
  logic [TimeW-1:0]       term;
  logic [TimeW:0]         sum;
  logic [CntW+ValW-1:0]   occ_w, least_w, most_w;
  logic [AddrW+SlotW-1:0] slot_w;
  logic [AddrW+IdxW-1:0]  idx_w;
  result_t                result_d;

  // Slots in use and the next interval boundary.
  assign lim    = (icnt_q < LimCap) ? icnt_q : LimCap;
  assign next_b = {1'b0, bound_q} + {1'b0, ilen_q};

  assign status_o.slot_full    = (slot_q >= lim);
  assign status_o.close_step   = (slot_q < lim) && ({1'b0, t_q} > next_b);
  assign status_o.before_start = (t_q < start_q);

  // Saturating count step.
  always_comb begin
    occ_n = occ_q;
    if (up_q) begin
      if (occ_q != {CntW{1'b1}}) occ_n = occ_q + CntW'(1);
    end else begin
      if (occ_q != '0) occ_n = occ_q - CntW'(1);
    end
  end

  // Elapsed time inside the window.
  assign tc = (t_q < end_q) ? t_q : end_q;
  assign d  = (tc > prior_q) ? tc - prior_q : '0;

  // One shared 32x32 multiplier: first span fraction, then fraction times count.
  assign mul_a = cmd_i.mul_second ? mul_q[47:16] : d_q;
  assign mul_b = cmd_i.mul_second ? 32'(occ_q) : recip_q;
  assign prod  = 64'(mul_a) * 64'(mul_b);

  // Saturating accumulation of the weighted term.
  assign term_sat = (big_q && (occ_q != '0)) || (|mul_q[63:32]);
  assign term     = term_sat ? {TimeW{1'b1}} : mul_q[31:0];
  assign sum      = {1'b0, wsum_q} + {1'b0, term};

  // Widen narrow counts before taking the 16-bit output fields.
  assign occ_w   = (CntW+ValW)'(occ_q);
  assign least_w = (CntW+ValW)'(least_q);
  assign most_w  = (CntW+ValW)'(most_q);
  assign slot_w  = {{AddrW{1'b0}}, slot_q};
  assign idx_w   = {{AddrW{1'b0}}, idx_q};

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= StartReset;
      end_q   <= EndReset;
      ilen_q  <= IlenReset;
      icnt_q  <= IcntReset;
      recip_q <= RecipReset;
      first_q <= FirstReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_START: start_q <= cfg_data_i;
        CFG_END:   end_q   <= cfg_data_i;
        CFG_ILEN:  ilen_q  <= cfg_data_i;
        CFG_ICNT:  icnt_q  <= cfg_data_i[SlotW-1:0];
        CFG_RECIP: recip_q <= cfg_data_i;
        CFG_FIRST: first_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Statistics update.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q     <= '0;
      least_q   <= '0;
      most_q    <= '0;
      slot_q    <= '0;
      wsum_q    <= '0;
      least_t_q <= StartReset;
      most_t_q  <= StartReset;
      late_q    <= StartReset;
      prior_q   <= StartReset;
      bound_q   <= StartReset;
      early_q   <= FirstReset;
    end else if (cmd_i.clear) begin
      occ_q     <= '0;
      least_q   <= '0;
      most_q    <= '0;
      slot_q    <= '0;
      wsum_q    <= '0;
      least_t_q <= start_q;
      most_t_q  <= start_q;
      late_q    <= start_q;
      prior_q   <= start_q;
      bound_q   <= start_q;
      early_q   <= first_q;
    end else begin
      if (cmd_i.close) begin
        slot_q  <= slot_q + SlotW'(1);
        bound_q <= next_b[TimeW-1:0];
      end
      if (cmd_i.update) begin
        occ_q <= occ_n;
        if (t_q < start_q) begin
          early_q <= start_q;
        end else if (t_q < early_q) begin
          early_q <= t_q;
        end
        if (t_q > end_q) begin
          late_q <= end_q;
        end else if (t_q > late_q) begin
          late_q <= t_q;
        end
        if (status_o.before_start) begin
          least_q   <= occ_n;
          most_q    <= occ_n;
          least_t_q <= start_q;
          most_t_q  <= start_q;
          prior_q   <= start_q;
        end else begin
          if ((occ_n > most_q) && (t_q <= end_q)) begin
            most_q   <= occ_n;
            most_t_q <= t_q;
          end
          if ((occ_n < least_q) && (t_q <= end_q)) begin
            least_q   <= occ_n;
            least_t_q <= t_q;
          end
          prior_q <= tc;
        end
      end
      if (cmd_i.accum) begin
        wsum_q <= sum[TimeW] ? {TimeW{1'b1}} : sum[TimeW-1:0];
      end
    end
  end

  // Request latch, multiplier pipeline and output register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      t_q   <= in_time_i;
      idx_q <= in_index_i;
      up_q  <= (in_action_i == ACT_INC);
      hit_q <= 1'b0;
    end
    if (cmd_i.update) d_q <= d;
    if (cmd_i.mul_first) mul_q <= prod;
    if (cmd_i.mul_second) begin
      mul_q <= prod;
      big_q <= |mul_q[63:48];
    end
    if (cmd_i.read) hit_q <= ({1'b0, idx_q} < slot_q);
    if (cmd_i.out_load) result_q <= result_d;
  end

  // Interval store: one write port for closing, one registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.close) store_q[slot_w[AddrW-1:0]] <= occ_w[ValW-1:0];
    if (cmd_i.read) rd_q <= store_q[idx_w[AddrW-1:0]];
  end

  // Result assembly from the state after the request.
  always_comb begin
    result_d                  = '0;
    result_d.current_count    = occ_w[ValW-1:0];
    result_d.min_count        = least_w[ValW-1:0];
    result_d.min_time         = least_t_q;
    result_d.max_count        = most_w[ValW-1:0];
    result_d.max_time         = most_t_q;
    result_d.first_entry      = early_q;
    result_d.last_exit        = late_q;
    result_d.average_count    = wsum_q;
    result_d.interval_value   = hit_q ? rd_q : '0;
    result_d.intervals_closed = slot_q;
  end

  assign result_o = result_q;

  // A slot is only closed while slots remain.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.close |-> (slot_q < lim))
    else $error("interval closed beyond the slots in use");

  // An event before the window start leaves min and max equal.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.update && status_o.before_start && !cmd_i.clear) |=> (least_q == most_q))
    else $error("min and max differ after an event before the window");

  // Accumulating never lowers the weighted sum.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.accum && !cmd_i.clear) |=> (wsum_q >= $past(wsum_q)))
    else $error("weighted sum went down on accumulation");

endmodule

@@ src/ost_ctrl.sv @@
module ost_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  ost_pkg::action_e      in_action_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  ost_pkg::ost_status_t  status_i,
  output ost_pkg::ost_cmd_t     cmd_o
);
  import ost_pkg::*;

  typedef enum logic [9:0] {
    ST_IDLE   = 10'b00_0000_0001,
    ST_CHECK  = 10'b00_0000_0010,
    ST_CLOSE  = 10'b00_0000_0100,
    ST_UPDATE = 10'b00_0000_1000,
    ST_MUL1   = 10'b00_0001_0000,
    ST_MUL2   = 10'b00_0010_0000,
    ST_ACC    = 10'b00_0100_0000,
    ST_CLEAR  = 10'b00_1000_0000,
    ST_READ   = 10'b01_0000_0000,
    ST_DONE   = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;

  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  // Sequencer: one request at a time, one interval closed per cycle.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          case (in_action_i)
            ACT_INC, ACT_DEC: state_d = ST_CHECK;
            ACT_CLEAR:        state_d = ST_CLEAR;
            ACT_READ:         state_d = ST_READ;
            default:          state_d = ST_DONE;
          endcase
        end
      end
      ST_CHECK: begin
        state_d = status_i.slot_full ? ST_DONE : ST_CLOSE;
      end
      ST_CLOSE: begin
        if (status_i.close_step) begin
          cmd_o.close = 1'b1;
        end else begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d = status_i.before_start ? ST_DONE : ST_MUL1;
      end
      ST_MUL1: begin
        cmd_o.mul_first = 1'b1;
        state_d = ST_MUL2;
      end
      ST_MUL2: begin
        cmd_o.mul_second = 1'b1;
        state_d = ST_ACC;
      end
      ST_ACC: begin
        cmd_o.accum = 1'b1;
        state_d = ST_DONE;
      end
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        state_d = ST_DONE;
      end
      ST_READ: begin
        cmd_o.read = 1'b1;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Output register valid flag.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // An accepted request keeps the input closed on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_ready_o)
    else $error("input ready right after an accepted request");

  // A result never overwrites one that has not been taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || out_ready_i))
    else $error("output register overwritten while full");

  // A new result appears only after the finishing state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DONE))
    else $error("result valid without a finished request");

endmodule

@@ src/occupancy_statistics_tracker.sv @@
// Occupancy statistics tracker.
// Input stream: each request carries a kind on s_axis_tuser (increment,
// decrement, clear or read) and an event time and slot index on tdata.
// Output stream: one result per request, the statistics after it, with the
// stored interval value for a read and zero otherwise.
// Configuration is a write port (enable, index, data), to be used only while
// idle; the block itself does not enforce this. Requests are handled one at
// a time by a controller that steps a datapath: an event passes through
// check, interval closing, update, the multiplier passes and accumulation,
// then a finishing state loads the result. Intervals are closed one store
// write per cycle. The average needs two passes through one shared 32x32
// multiplier. An event before the window start skips the average. An event
// with all slots closed goes from check straight to finishing, and a clear
// or a read passes only through its own state before finishing.
// The result register lets the next request be accepted while a result
// waits; a stalled receiver holds the result, and the block stops before
// loading another one until it is taken.
// Reset loads the default configuration and clears all statistics; the
// interval store needs no clearing, as slots at or above the closed count
// read as zero.
module occupancy_statistics_tracker #(
  parameter int MAX_INTERVALS = 1024,
  parameter int COUNT_BITS    = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ost_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [ost_pkg::TimeW-1:0]      cfg_data_i,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // tdata: event_time[31:0], read_index[41:32], zero fill[47:42]
  input  logic [ost_pkg::InDataW-1:0]    s_axis_tdata,
  // tuser: action[1:0]
  input  logic [1:0]                     s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // tdata: current_count[15:0], min_count[31:16], min_time[63:32],
  // max_count[79:64], max_time[111:80], first_entry[143:112],
  // last_exit[175:144], average_count[207:176], interval_value[223:208],
  // intervals_closed[234:224], zero fill[239:235]
  output logic [ost_pkg::OutDataW-1:0]   m_axis_tdata
);
  import ost_pkg::*;

  action_e     action;
  ost_cmd_t    cmd;
  ost_status_t status;
  result_t     result;

  assign action       = action_e'(s_axis_tuser);
  assign m_axis_tdata = result;

  ost_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_action_i (action),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  ost_datapath #(
    .MAX_INTERVALS (MAX_INTERVALS),
    .COUNT_BITS    (COUNT_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_action_i (action),
    .in_time_i   (s_axis_tdata[TimeW-1:0]),
    .in_index_i  (s_axis_tdata[TimeW+IdxW-1:TimeW]),
    .cmd_i       (cmd),
    .status_o    (status),
    .result_o    (result)
  );

endmodule

@@ bench/occupancy_stats_checker.sv @@
`timescale 1ns / 100ps

// Watches the configuration port and both streams. It keeps its own copy
// of the occupancy statistics, works out the result of every accepted
// request, and compares each accepted result with the oldest one due.
module occupancy_stats_checker
  import ost_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [TimeW-1:0]    cfg_data_i,
  input  logic                req_valid_i,
  input  logic                req_ready_i,
  input  logic [InDataW-1:0]  req_data_i,
  input  logic [1:0]          req_kind_i,
  input  logic                res_valid_i,
  input  logic                res_ready_i,
  input  logic [OutDataW-1:0] res_data_i,
  output int                  fail_count_o,
  output int                  pending_o
);

  localparam int SlotDepth = 1024;
  localparam logic [ValW-1:0] CountTop = '1;

  // Register copies.
  logic [TimeW-1:0] win_start, win_end, slot_len, recip_span, first_init;
  logic [SlotW-1:0] slot_limit;

  // Statistics copies.
  logic [ValW-1:0]  occupancy, least_cnt, most_cnt;
  logic [TimeW-1:0] least_at, most_at, earliest_at, latest_at;
  logic [TimeW-1:0] prior_at, boundary_at, weighted_sum;
  logic [SlotW-1:0] slots_closed;
  logic [ValW-1:0]  slot_store [SlotDepth];

  // Results of accepted requests that have not come out yet.
  result_t stats_due[$];

  // A clear restarts everything from the current registers.
  function automatic void restart_stats();
    for (int i = 0; i < SlotDepth; i++) begin
      slot_store[i] = '0;
    end
    occupancy    = '0;
    least_cnt    = '0;
    most_cnt     = '0;
    slots_closed = '0;
    weighted_sum = '0;
    least_at     = win_start;
    most_at      = win_start;
    latest_at    = win_start;
    prior_at     = win_start;
    boundary_at  = win_start;
    earliest_at  = first_init;
  endfunction

  // One increment or decrement event at time t.
  function automatic void take_event(bit up, logic [TimeW-1:0] t);
    logic [SlotW-1:0] lim;
    logic [TimeW:0]   next_b;
    logic [TimeW-1:0] tc, span_d, term_sat;
    logic [63:0]      frac, term;
    logic [TimeW:0]   sum;
    lim = (slot_limit < 11'd1024) ? slot_limit : 11'd1024;
    // With every slot closed the event has no effect at all.
    if (slots_closed >= lim) return;

    // Close each whole interval that lies before the event.
    while (boundary_at < t && slots_closed < lim) begin
      next_b = {1'b0, boundary_at} + {1'b0, slot_len};
      if ({1'b0, t} <= next_b) break;
      slot_store[slots_closed[9:0]] = occupancy;
      slots_closed++;
      boundary_at = next_b[TimeW-1:0];
    end

    // The count saturates at both ends.
    if (up) begin
      if (occupancy < CountTop) occupancy++;
    end else if (occupancy > 0) begin
      occupancy--;
    end

    if (t < win_start) begin
      earliest_at = win_start;
    end else if (t < earliest_at) begin
      earliest_at = t;
    end
    if (t > win_end) begin
      latest_at = win_end;
    end else if (t > latest_at) begin
      latest_at = t;
    end

    if (t < win_start) begin
      // Before the window the extremes follow the count.
      least_cnt = occupancy;
      most_cnt  = occupancy;
      least_at  = win_start;
      most_at   = win_start;
      prior_at  = win_start;
    end else begin
      if (occupancy > most_cnt && t <= win_end) begin
        most_cnt = occupancy;
        most_at  = t;
      end
      if (occupancy < least_cnt && t <= win_end) begin
        least_cnt = occupancy;
        least_at  = t;
      end
      // Time-weighted count; elapsed time is zero when time goes back.
      tc     = (t < win_end) ? t : win_end;
      span_d = (tc > prior_at) ? tc - prior_at : '0;
      frac   = ({32'b0, span_d} * {32'b0, recip_span}) >> 16;
      term   = frac * {48'b0, occupancy};
      term_sat = (term > 64'hFFFF_FFFF) ? '1 : term[TimeW-1:0];
      sum = {1'b0, weighted_sum} + {1'b0, term_sat};
      weighted_sum = sum[TimeW] ? '1 : sum[TimeW-1:0];
      prior_at = tc;
    end
  endfunction

  // Applies one request and returns the statistics after it.
  function automatic result_t apply_request(logic [1:0] kind, logic [TimeW-1:0] t,
                                            logic [IdxW-1:0] idx);
    result_t r;
    logic [ValW-1:0] read_val;
    read_val = '0;
    case (action_e'(kind))
      ACT_INC:   take_event(1'b1, t);
      ACT_DEC:   take_event(1'b0, t);
      ACT_CLEAR: restart_stats();
      default:   read_val = slot_store[idx];
    endcase
    r = '0;
    r.current_count    = occupancy;
    r.min_count        = least_cnt;
    r.min_time         = least_at;
    r.max_count        = most_cnt;
    r.max_time         = most_at;
    r.first_entry      = earliest_at;
    r.last_exit        = latest_at;
    r.average_count    = weighted_sum;
    r.interval_value   = read_val;
    r.intervals_closed = slots_closed;
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      fail_count_o++;
    end
  endfunction

  function automatic void compare_stats(result_t exp_r, result_t got_r);
    check_field("current_count", 32'(exp_r.current_count), 32'(got_r.current_count));
    check_field("min_count", 32'(exp_r.min_count), 32'(got_r.min_count));
    check_field("min_time", exp_r.min_time, got_r.min_time);
    check_field("max_count", 32'(exp_r.max_count), 32'(got_r.max_count));
    check_field("max_time", exp_r.max_time, got_r.max_time);
    check_field("first_entry", exp_r.first_entry, got_r.first_entry);
    check_field("last_exit", exp_r.last_exit, got_r.last_exit);
    check_field("average_count", exp_r.average_count, got_r.average_count);
    check_field("interval_value", 32'(exp_r.interval_value), 32'(got_r.interval_value));
    check_field("intervals_closed", 32'(exp_r.intervals_closed),
                32'(got_r.intervals_closed));
  endfunction

  // Everything is sampled at the rising edge, before the edge's updates land.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_start  = StartReset;
      win_end    = EndReset;
      slot_len   = IlenReset;
      slot_limit = IcntReset;
      recip_span = RecipReset;
      first_init = FirstReset;
      restart_stats();
      stats_due.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_START: win_start  = cfg_data_i;
          CFG_END:   win_end    = cfg_data_i;
          CFG_ILEN:  slot_len   = cfg_data_i;
          CFG_ICNT:  slot_limit = cfg_data_i[SlotW-1:0];
          CFG_RECIP: recip_span = cfg_data_i;
          CFG_FIRST: first_init = cfg_data_i;
          default: ;
        endcase
      end
      if (res_valid_i && res_ready_i) begin
        if (stats_due.size() == 0) begin
          $error("result arrived with no request outstanding");
          fail_count_o++;
        end else begin
          compare_stats(stats_due.pop_front(), result_t'(res_data_i));
        end
      end
      if (req_valid_i && req_ready_i) begin
        stats_due.push_back(apply_request(req_kind_i, req_data_i[31:0], req_data_i[41:32]));
      end
      pending_o = stats_due.size();
    end
  end

endmodule

@@ bench/occupancy_statistics_tracker_test.sv @@
`timescale 1ns / 100ps

module occupancy_statistics_tracker_test;
  import ost_pkg::*;

  // Longest stretch without any accepted request or result: the receiver
  // hold-off plus an event that closes every slot, several times over.
  localparam int StallLimit = 6000;
  localparam int HoldCycles = 300;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = CFG_START;
  logic [TimeW-1:0]    cfg_data_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic [1:0]          s_axis_tuser = ACT_INC;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;

  int fail_count;
  int pending;
  int idle_cycles = 0;
  bit tx_gaps = 1'b1;
  bit rx_gaps = 1'b1;
  bit hold_req = 1'b0;

  // Window of the current phase, used to shape event times.
  logic [TimeW-1:0] ph_start = StartReset;
  logic [SlotW-1:0] ph_count = IcntReset;
  logic [63:0]      now_t;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  occupancy_statistics_tracker dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  occupancy_stats_checker stats_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .req_valid_i  (s_axis_tvalid),
    .req_ready_i  (s_axis_tready),
    .req_data_i   (s_axis_tdata),
    .req_kind_i   (s_axis_tuser),
    .res_valid_i  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_data_i   (m_axis_tdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Offers one request and returns at the edge where it is accepted.
  task automatic send_req(action_e act, logic [TimeW-1:0] t, logic [IdxW-1:0] idx);
    int gap;
    if (tx_gaps && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 12);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, idx, t};
    s_axis_tuser  <= act;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Waits until every outstanding result has been taken.
  task automatic drain();
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [TimeW-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
  endtask

  // Registers are only written once the block has gone idle.
  task automatic set_config(logic [TimeW-1:0] t0, logic [TimeW-1:0] t1,
                            logic [TimeW-1:0] len, logic [SlotW-1:0] cnt,
                            logic [TimeW-1:0] recip, logic [TimeW-1:0] first);
    s_axis_tvalid <= 1'b0;
    drain();
    write_reg(CFG_START, t0);
    write_reg(CFG_END, t1);
    write_reg(CFG_ILEN, len);
    write_reg(CFG_ICNT, 32'(cnt));
    write_reg(CFG_RECIP, recip);
    write_reg(CFG_FIRST, first);
    cfg_we_i <= 1'b0;
    ph_start = t0;
    ph_count = cnt;
  endtask

  function automatic logic [TimeW-1:0] span_recip(logic [TimeW-1:0] span);
    logic [63:0] q;
    if (span == 0) return '1;
    q = 64'h1_0000_0000 / {32'b0, span};
    return (q > 64'hFFFF_FFFF) ? '1 : q[TimeW-1:0];
  endfunction

  // Mostly time-ordered events walking through the window, with reads,
  // the odd clear, and events at random times as noise.
  task automatic run_phase(int n, int step_max, int up_pct);
    int roll;
    logic [TimeW-1:0] t;
    logic [IdxW-1:0] idx;
    action_e act;
    now_t = (ph_start > 300) ? 64'(ph_start - $urandom_range(0, 300)) : 64'd0;
    repeat (n) begin
      roll = $urandom_range(0, 99);
      t    = $urandom();
      idx  = $urandom_range(0, 1023);
      if (roll < 3) begin
        act   = ACT_CLEAR;
        now_t = 64'(ph_start);
      end else if (roll < 15) begin
        act = ACT_READ;
        if (roll < 11) begin
          idx = $urandom_range(0, (ph_count > 11'd1024) ? 1023 : int'(ph_count) - 1);
        end
      end else if (roll < 21) begin
        act = $urandom_range(0, 1) ? ACT_INC : ACT_DEC;
      end else begin
        act   = ($urandom_range(0, 99) < up_pct) ? ACT_INC : ACT_DEC;
        now_t = now_t + $urandom_range(0, step_max);
        if (now_t > 64'hFFFF_FFFF) now_t = 64'hFFFF_FFFF;
        t = now_t[TimeW-1:0];
      end
      send_req(act, t, idx);
    end
  endtask

  // Receiver: random stalls, and one long hold-off when asked for.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else if (rx_gaps && $urandom_range(0, 7) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Ends the run if nothing moves on either stream for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [TimeW-1:0] r_start, r_span, r_len;
    logic [SlotW-1:0] r_cnt;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Default registers: counting down past zero, a boundary hit exactly,
    // intervals closing, time going back, events past the window end and
    // at the largest time, all slots closed, then a clear.
    send_req(ACT_READ, 32'd0, 10'd0);
    send_req(ACT_DEC, 32'd0, 10'd0);
    send_req(ACT_INC, 32'd0, 10'd0);
    send_req(ACT_INC, 32'd100, 10'd0);
    send_req(ACT_INC, 32'd3600, 10'd0);
    send_req(ACT_INC, 32'd3601, 10'd0);
    send_req(ACT_DEC, 32'd10000, 10'd0);
    send_req(ACT_READ, 32'd0, 10'd1);
    send_req(ACT_INC, 32'd5000, 10'd0);
    send_req(ACT_INC, 32'd90000, 10'd0);
    send_req(ACT_INC, 32'hFFFF_FFFF, 10'd0);
    send_req(ACT_DEC, 32'd200000, 10'd0);
    send_req(ACT_READ, 32'hFFFF_FFFF, 10'd1023);
    send_req(ACT_CLEAR, 32'd0, 10'd0);
    send_req(ACT_READ, 32'd0, 10'd24);

    // Zero interval length fills every slot at once; an event before the
    // window start resets the extremes.
    set_config(32'd1000, 32'd9000, 32'd0, 11'd1024, '1, 32'd0);
    send_req(ACT_INC, 32'd500, 10'd0);
    send_req(ACT_INC, 32'd1000, 10'd0);
    send_req(ACT_INC, 32'd8000, 10'd0);
    send_req(ACT_READ, 32'd0, 10'd1023);

    // With the slots still all closed from the phase before, these events have no effect.
    set_config(32'd1, '1, '1, 11'd1, '1, '1);
    send_req(ACT_INC, 32'd0, 10'd0);
    send_req(ACT_INC, 32'd1, 10'd0);
    send_req(ACT_INC, 32'h8000_0000, 10'd0);
    send_req(ACT_DEC, 32'hFFFF_FFFF, 10'd0);
    send_req(ACT_READ, 32'd0, 10'd0);

    // Random phases; the first one starts under a long receiver hold-off.
    set_config(32'd1000, 32'd61000, 32'd600, 11'd101, span_recip(32'd60000), 32'd61000);
    hold_req = 1'b1;
    run_phase(200, 770, 60);

    set_config(32'd0, '1, 32'h0040_0000, 11'd1024, 32'd1, '1);
    run_phase(200, 55000000, 50);

    set_config(32'd5000, 32'd6000, 32'd1, 11'd1024, span_recip(32'd1000), 32'd0);
    run_phase(150, 16, 70);

    set_config(32'hFFFF_FF00, '1, 32'd64, 11'd3, 32'd0, 32'd12345);
    run_phase(100, 4, 55);

    for (int p = 0; p < 3; p++) begin
      r_start = $urandom_range(0, 1000000);
      r_span  = $urandom_range(1, 5000000);
      r_cnt   = $urandom_range(1, 1024);
      r_len   = r_span / 32'(r_cnt) + $urandom_range(0, 50);
      set_config(r_start, r_start + r_span, r_len, r_cnt, span_recip(r_span), $urandom());
      // The last phase runs with no gaps on either stream.
      if (p == 2) begin
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
      end
      run_phase(170, int'(2 * r_span / 130) + 1, $urandom_range(40, 70));
    end

    s_axis_tvalid <= 1'b0;
    drain();
    repeat (24) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
